FILE: rtl/core/idt_pkg.sv
// Package of the ID-to-index offset table: item types, operation and status codes,
// and the controller state type. It depends on nothing.
`default_nettype none

package idt_pkg;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_BUILD  = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_GET    = 3'd3;
    localparam logic [2:0] OP_GET_ID = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_SPAN     = 3'd3;
    localparam logic [2:0] ST_NOTBUILT = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic signed [31:0] VALUE_NONE = -32'sd1;
    localparam logic [15:0]        SLOT_NONE  = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] id;
        logic signed [15:0] index;
        logic [5:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_ENTRY,
        S_RD_TABLE,
        S_SCAN,
        S_SPAN,
        S_FILL,
        S_PLACE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/idt_spram.sv
// Single-port synchronous RAM with a registered read port.
// It is used for the ID list and for the index table; it depends on nothing.
`default_nettype none

module idt_spram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic             i_we,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/id_to_index_offset_table.sv
// Top level of the ID-to-index offset table: command decode, build sequencer and
// result register. It depends on idt_pkg and on idt_spram for the list and the table.
//
// An item transfers when start is high and busy is low; its result appears on o_result
// with o_strobe high for exactly one cycle and the receiver cannot stall it. Append,
// clear, set and every error except a span that is too large answer in the cycle after the
// transfer, and busy stays low, so such items can follow each cycle. Get index and get
// id read a synchronous memory, pass through a read state and answer from the result
// register. A build scans the listed IDs for their bounds, checks the span, fills the
// table slots of the span with -1 and then places the positions; a build whose span is
// larger than the table answers after the span check. The single table port sets the
// fill and place time. The table has no clearing pass after reset: it is only read
// after a successful build.
`default_nettype none

module id_to_index_offset_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire idt_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_strobe,
    output idt_pkg::t_out_item     o_result
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    idt_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_built, n_built;
    logic signed [31:0] r_lowest, n_lowest;
    logic signed [31:0] r_highest, n_highest;
    logic [EW-1:0]      r_ptr, n_ptr;
    logic [TW-1:0]      r_fill, n_fill;
    logic [TW-1:0]      r_last, n_last;
    logic               r_strobe, n_strobe;
    idt_pkg::t_out_item r_result, n_result;

    logic [EW-1:0]      e_addr;
    logic               e_we;
    logic [31:0]        e_wdata;
    logic [31:0]        e_rdata;
    logic [TW-1:0]      t_addr;
    logic               t_we;
    logic [15:0]        t_wdata;
    logic [15:0]        t_rdata;

    logic               accept;
    logic               lookup_ok;
    logic [31:0]        slot;
    logic               pos_ok;
    logic               ptr_last;
    logic signed [31:0] e_val;
    logic signed [32:0] span_diff;
    logic               span_big;
    logic [31:0]        place_slot;

    idt_spram #(.DEPTH(MAX_ENTRIES), .WIDTH(32), .AW(EW)) u_entry_mem (
        .i_clk  (i_clk),
        .i_addr (e_addr),
        .i_we   (e_we),
        .i_wdata(e_wdata),
        .o_rdata(e_rdata)
    );

    idt_spram #(.DEPTH(TABLE_DEPTH), .WIDTH(16), .AW(TW)) u_table_mem (
        .i_clk  (i_clk),
        .i_addr (t_addr),
        .i_we   (t_we),
        .i_wdata(t_wdata),
        .o_rdata(t_rdata)
    );

    assign busy     = (r_state != idt_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign slot      = i_item.id - r_lowest;
    assign lookup_ok = r_built && (i_item.id >= r_lowest) && (i_item.id <= r_highest)
                       && (slot < 32'(TABLE_DEPTH));
    assign pos_ok    = 32'(i_item.position) < 32'(r_count);
    assign ptr_last  = (CW'(r_ptr) == (r_count - CW'(1)));
    assign e_val     = e_rdata;
    assign span_diff = {r_highest[31], r_highest} - {r_lowest[31], r_lowest};
    assign span_big  = span_diff > 33'(TABLE_DEPTH - 1);
    assign place_slot = e_val - r_lowest;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            idt_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_item.operation) inside
                        idt_pkg::OP_BUILD: begin
                            if (r_count != '0) n_state = idt_pkg::S_SCAN;
                        end
                        idt_pkg::OP_GET: begin
                            if (lookup_ok) n_state = idt_pkg::S_RD_TABLE;
                        end
                        idt_pkg::OP_GET_ID: begin
                            if (pos_ok) n_state = idt_pkg::S_RD_ENTRY;
                        end
                        default: n_state = idt_pkg::S_IDLE;
                    endcase
                end
            end
            idt_pkg::S_RD_ENTRY: n_state = idt_pkg::S_IDLE;
            idt_pkg::S_RD_TABLE: n_state = idt_pkg::S_IDLE;
            idt_pkg::S_SCAN: begin
                if (ptr_last) n_state = idt_pkg::S_SPAN;
            end
            idt_pkg::S_SPAN: begin
                n_state = span_big ? idt_pkg::S_IDLE : idt_pkg::S_FILL;
            end
            idt_pkg::S_FILL: begin
                if (r_fill == r_last) n_state = idt_pkg::S_PLACE;
            end
            idt_pkg::S_PLACE: begin
                if (ptr_last) n_state = idt_pkg::S_IDLE;
            end
            default: n_state = idt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_built   = r_built;
        n_lowest  = r_lowest;
        n_highest = r_highest;
        n_ptr     = r_ptr;
        n_fill    = r_fill;
        n_last    = r_last;
        n_strobe  = 1'b0;
        n_result  = r_result;
        e_addr    = r_ptr;
        e_we      = 1'b0;
        e_wdata   = i_item.id;
        t_addr    = r_fill;
        t_we      = 1'b0;
        t_wdata   = idt_pkg::SLOT_NONE;
        unique case (r_state)
            idt_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_item.operation) inside
                        idt_pkg::OP_APPEND: begin
                            n_strobe = 1'b1;
                            if (r_count == CW'(MAX_ENTRIES)) begin
                                n_result = '{idt_pkg::ST_FULL, idt_pkg::VALUE_NONE};
                            end else begin
                                e_we     = 1'b1;
                                e_addr   = EW'(r_count);
                                n_count  = r_count + CW'(1);
                                n_result = '{idt_pkg::ST_OK, 32'(r_count)};
                            end
                        end
                        idt_pkg::OP_BUILD: begin
                            e_addr = '0;
                            n_ptr  = '0;
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result = '{idt_pkg::ST_EMPTY, idt_pkg::VALUE_NONE};
                            end
                        end
                        idt_pkg::OP_SET, idt_pkg::OP_GET: begin
                            t_addr = TW'(slot);
                            if (!lookup_ok) begin
                                n_strobe = 1'b1;
                                n_result = '{r_built ? idt_pkg::ST_RANGE : idt_pkg::ST_NOTBUILT,
                                             idt_pkg::VALUE_NONE};
                            end else if (i_item.operation == idt_pkg::OP_SET) begin
                                t_we     = 1'b1;
                                t_wdata  = i_item.index;
                                n_strobe = 1'b1;
                                n_result = '{idt_pkg::ST_OK, 32'sd0};
                            end
                        end
                        idt_pkg::OP_GET_ID: begin
                            e_addr = EW'(i_item.position);
                            if (!pos_ok) begin
                                n_strobe = 1'b1;
                                n_result = '{idt_pkg::ST_RANGE, idt_pkg::VALUE_NONE};
                            end
                        end
                        idt_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_strobe = 1'b1;
                            n_result = '{idt_pkg::ST_OK, 32'sd0};
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_result = '{idt_pkg::ST_RANGE, idt_pkg::VALUE_NONE};
                        end
                    endcase
                end
            end
            idt_pkg::S_RD_ENTRY: begin
                n_strobe = 1'b1;
                n_result = '{idt_pkg::ST_OK, e_val};
            end
            idt_pkg::S_RD_TABLE: begin
                n_strobe = 1'b1;
                n_result = '{idt_pkg::ST_OK, {{16{t_rdata[15]}}, t_rdata}};
            end
            idt_pkg::S_SCAN: begin
                if (r_ptr == '0) begin
                    n_lowest  = e_val;
                    n_highest = e_val;
                end else begin
                    if (e_val < r_lowest)  n_lowest  = e_val;
                    if (e_val > r_highest) n_highest = e_val;
                end
                e_addr = r_ptr + EW'(1);
                n_ptr  = r_ptr + EW'(1);
            end
            idt_pkg::S_SPAN: begin
                n_last = span_diff[TW-1:0];
                n_fill = '0;
                if (span_big) begin
                    n_built  = 1'b0;
                    n_strobe = 1'b1;
                    n_result = '{idt_pkg::ST_SPAN, idt_pkg::VALUE_NONE};
                end
            end
            idt_pkg::S_FILL: begin
                t_we   = 1'b1;
                t_addr = r_fill;
                n_fill = r_fill + TW'(1);
                e_addr = '0;
                n_ptr  = '0;
            end
            idt_pkg::S_PLACE: begin
                t_we    = 1'b1;
                t_addr  = place_slot[TW-1:0];
                t_wdata = 16'(r_ptr);
                e_addr  = r_ptr + EW'(1);
                n_ptr   = r_ptr + EW'(1);
                if (ptr_last) begin
                    n_built  = 1'b1;
                    n_strobe = 1'b1;
                    n_result = '{idt_pkg::ST_OK, 32'sd0};
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= idt_pkg::S_IDLE;
            r_count   <= '0;
            r_built   <= 1'b0;
            r_lowest  <= '0;
            r_highest <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_built   <= n_built;
            r_lowest  <= n_lowest;
            r_highest <= n_highest;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_fill   <= n_fill;
        r_last   <= n_last;
        r_result <= n_result;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("list count exceeds capacity");

    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status != idt_pkg::ST_OK) |-> o_result.value == -32'sd1)
        else $error("error result without the none value");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ((i_item.operation == idt_pkg::OP_APPEND)
                   || (i_item.operation == idt_pkg::OP_CLEAR)) |=> o_strobe && !busy)
        else $error("append or clear did not answer in one cycle");

    a_get_id_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.operation == idt_pkg::OP_GET_ID) && pos_ok
        |=> !o_strobe ##1 o_strobe)
        else $error("get id did not answer after the memory read");

    a_table_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_we |-> (r_state == idt_pkg::S_IDLE) || (r_state == idt_pkg::S_FILL)
                 || (r_state == idt_pkg::S_PLACE))
        else $error("table written outside set, fill or place");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(r_state == idt_pkg::S_PLACE) |-> r_built)
        else $error("build finished without marking the table built");

endmodule

`default_nettype wire
